// File: rtl/core/sha_pkg.sv
`default_nettype none
package sha_pkg;

	typedef logic [31:0] word_t;

	localparam word_t INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	// compression unit interface
	typedef struct packed {
		logic start;
		logic init;
	} cmp_ctl_t;

	typedef struct packed {
		logic busy;
	} cmp_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/sha_compress.sv
`default_nettype none
module sha_compress import sha_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmp_ctl_t    ctl,
	input  wire logic [31:0] blk_word,
	output logic [3:0]       blk_idx,
	input  wire logic [2:0]  hrd_idx,
	output word_t            hrd_word,
	output cmp_sts_t         sts
);
	// one round per cycle, 64 rounds then a fold into the chaining words
	word_t   h_q [8];
	word_t   v_q [8];
	word_t   w_q [16];
	logic [6:0] rnd_q;
	logic       busy_q;

	word_t w_t, s0, s1, big0, big1, ch, mj, t1;
	logic [5:0] t;

	assign t = rnd_q[5:0];
	assign blk_idx = t[3:0];
	assign sts.busy = busy_q;
	assign hrd_word = h_q[hrd_idx];

	always_comb begin
		s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
		s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
			^ (w_q[14] >> 10);
		w_t = (t < 6'd16) ? blk_word : w_q[0] + s0 + w_q[9] + s1;
		big1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
			^ {v_q[4][24:0], v_q[4][31:25]};
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + big1 + ch + ROUND_K[t] + w_t;
		big0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
			^ {v_q[0][21:0], v_q[0][31:22]};
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			h_q    <= INIT_H;
		end else if (ctl.init) begin
			h_q <= INIT_H;
		end else if (ctl.start && !busy_q) begin
			busy_q <= 1'b1;
			rnd_q  <= '0;
		end else if (busy_q) begin
			if (rnd_q == 7'd64) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				busy_q <= 1'b0;
			end else begin
				rnd_q <= rnd_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q) begin
			v_q <= h_q;
		end else if (busy_q && rnd_q != 7'd64) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_t;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + big0 + mj;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/sha256_byte_stream_hasher_core.sv
`default_nettype none
// SHA-256 over a byte stream.
// Input channel (in_valid/in_stall): req_type 0 absorbs data_byte, req_type 1
// finishes the message. Output channel (out_valid/out_stall): eight digest
// words, H0 first, word_index 0..7, last_word on the eighth.
// A data byte that completes a 64-byte block starts its compression: 64
// rounds of one shared round unit plus a fold into the chaining words, and
// in_stall stays high until the fold is done.
// A finish writes padding one byte per cycle while the round unit is idle (up
// to 64 plus 8 length bytes) with one or two compressions, then presents the
// digest, one word per accepted output cycle.
// A stalled output word holds; no new input is taken until the last digest
// word is accepted, after which the hasher restarts with the initial values.
// Reset (arst_n low) clears lengths, fill count and chaining words at once.
module sha256_byte_stream_hasher_core import sha_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_WAIT = 5'b00010,
		ST_PAD  = 5'b00100,
		ST_LEN  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t      state_q;
	logic [31:0] buf_q [16];
	logic [5:0]  fill_q;
	logic [60:0] len_q;
	logic [63:0] bits_q;
	logic [2:0]  lcnt_q;
	logic [2:0]  oidx_q;
	logic        fin_q;
	logic [3:0]  blk_idx;
	cmp_ctl_t    ctl;
	cmp_sts_t    sts;
	word_t       hrd_word;
	logic        wr_en;
	logic [7:0]  wr_byte;
	logic [31:0] blk_word;

	// block buffer holds big-endian words; the round unit reads one per cycle
	assign blk_word = buf_q[blk_idx];

	sha_compress u_cmp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .blk_word(blk_word),
		.blk_idx(blk_idx), .hrd_idx(oidx_q), .hrd_word(hrd_word), .sts(sts)
	);

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = hrd_word;
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

	// byte writer: data, pad, or length byte
	always_comb begin
		wr_en   = 1'b0;
		wr_byte = data_byte;
		unique case (state_q)
			ST_IDLE: begin
				wr_en   = in_valid;
				wr_byte = req_type ? PAD_BYTE : data_byte;
			end
			ST_PAD: begin
				wr_en   = !sts.busy && fill_q != LEN_POS;
				wr_byte = 8'd0;
			end
			ST_LEN: begin
				wr_en   = !sts.busy;
				wr_byte = bits_q[63:56];
			end
			default: ;
		endcase
		ctl.start = wr_en && fill_q == 6'd63;
		ctl.init  = (state_q == ST_OUT) && !out_stall && oidx_q == 3'd7;
	end

	always_ff @(posedge clk) begin
		if (wr_en) buf_q[fill_q[5:2]][{~fill_q[1:0], 3'd0} +: 8] <= wr_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			len_q   <= '0;
			bits_q  <= '0;
			lcnt_q  <= '0;
			oidx_q  <= '0;
			fin_q   <= 1'b0;
		end else begin
			if (wr_en) fill_q <= fill_q + 6'd1;
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					if (req_type) begin
						bits_q  <= {len_q, 3'd0};
						state_q <= ST_PAD;
					end else begin
						len_q <= len_q + 61'd1;
						if (fill_q == 6'd63) state_q <= ST_WAIT;
					end
				end
				ST_WAIT: if (!sts.busy && !ctl.start) begin
					// hold until the round unit has folded the block
					state_q <= fin_q ? ST_OUT : ST_IDLE;
				end
				ST_PAD: if (!sts.busy && fill_q == LEN_POS) begin
					lcnt_q  <= '0;
					state_q <= ST_LEN;
				end
				ST_LEN: if (!sts.busy) begin
					bits_q <= {bits_q[55:0], 8'd0};
					lcnt_q <= lcnt_q + 3'd1;
					if (lcnt_q == 3'd7) begin
						fin_q   <= 1'b1;
						oidx_q  <= '0;
						state_q <= ST_WAIT;
					end
				end
				ST_OUT: if (!out_stall) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						fin_q   <= 1'b0;
						len_q   <= '0;
						fill_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
